// ===== sv/assert_macros.svh =====
// assertion macros used by the core rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain clocked assertion, disabled while reset is low
`define ISD_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// implication checked on the next clock edge
`define ISD_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/isd_pkg.sv =====
// shared types and codes of the indexed stack with delete
`timescale 1ns / 1ps

package isd_pkg;

    // command codes
    localparam logic [2:0] CMD_PUSH   = 3'd0;
    localparam logic [2:0] CMD_POP    = 3'd1;
    localparam logic [2:0] CMD_READ   = 3'd2;
    localparam logic [2:0] CMD_WRITE  = 3'd3;
    localparam logic [2:0] CMD_DELETE = 3'd4;
    localparam logic [2:0] CMD_CLEAR  = 3'd5;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    // port widths fixed by the interface
    localparam int unsigned CMD_W   = 3;
    localparam int unsigned INDEX_W = 6;
    localparam int unsigned WORD_W  = 32;
    localparam int unsigned COUNT_W = 7;

    // control broadcast to every cell
    typedef struct packed {
        logic load;   // cell at the select index takes the new entry
        logic shift;  // cells at and above the select index take their upper neighbor
    } cell_ctrl_t;

endpackage

// ===== sv/indexed_stack_with_delete_core.sv =====
// top level of the indexed stack with delete: command decode, cell chain, result register
//
// usage
//   input channel (s_valid / s_ready): one command word per handshake carrying
//   s_command, s_index and s_entry_data. push, pop, read at index, write at
//   index, delete at index and clear.
//   result channel (m_valid / m_ready): one result word per command with
//   m_status, m_read_data and m_entry_count (count after the command).
//   the result word is presented in the cycle after the command word is
//   taken. throughput: one command per cycle while m_ready stays high, since
//   every cell of the chain updates in the same cycle (delete shifts all upper
//   cells at once) and the read select is a one-hot or over the cells.
//   stall: while a result waits and m_ready is low, s_ready is low; the held
//   result word stays unchanged. with m_ready high a new command is taken in
//   the same cycle the previous result leaves.
//   reset: aresetn low (synchronous) clears the count and the result valid;
//   entries are not cleared. s_ready rises in the cycle after reset is released.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module indexed_stack_with_delete_core #(
    parameter int unsigned DEPTH       = 64,
    parameter int unsigned ENTRY_WIDTH = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [isd_pkg::CMD_W-1:0]     s_command,
    input  logic [isd_pkg::INDEX_W-1:0]   s_index,
    input  logic [isd_pkg::WORD_W-1:0]    s_entry_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [1:0]                    m_status,
    output logic [isd_pkg::WORD_W-1:0]    m_read_data,
    output logic [isd_pkg::COUNT_W-1:0]   m_entry_count
);

    localparam int unsigned IW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW   = $clog2(DEPTH + 1);
    localparam int unsigned CMPW = (CW > isd_pkg::INDEX_W) ? CW : isd_pkg::INDEX_W;
    localparam logic [CW-1:0]   DEPTH_C   = CW'(DEPTH);
    localparam logic [CMPW-1:0] DEPTH_CMP = CMPW'(DEPTH);

    // control state
    logic                          run_reg;
    logic [CW-1:0]                 count_reg;
    logic [CW-1:0]                 count_next;
    logic                          m_valid_reg;
    logic [1:0]                    m_status_reg;
    logic [1:0]                    m_status_next;
    logic [isd_pkg::WORD_W-1:0]    m_read_data_reg;
    logic [isd_pkg::WORD_W-1:0]    m_read_data_next;
    logic [isd_pkg::COUNT_W-1:0]   m_count_reg;

    // decode
    logic                          accept;
    logic [CMPW-1:0]               idx_w;
    logic [CMPW-1:0]               cnt_w;
    logic                          idx_below_count;
    logic                          idx_below_depth;
    logic                          is_full;
    logic                          is_empty;
    isd_pkg::cell_ctrl_t           ctrl;
    logic [IW-1:0]                 sel;
    logic [ENTRY_WIDTH-1:0]        load_data;

    // cell chain
    logic [ENTRY_WIDTH-1:0]        cell_q   [DEPTH];
    logic [ENTRY_WIDTH-1:0]        hit_q    [DEPTH];
    logic [ENTRY_WIDTH-1:0]        upper_in [DEPTH];
    logic [ENTRY_WIDTH-1:0]        sel_data;

    // after reset a command is taken whenever the result register is free or draining
    assign s_ready = run_reg && (!m_valid_reg || m_ready);
    assign accept  = s_valid && s_ready;

    assign idx_w           = CMPW'(s_index);
    assign cnt_w           = CMPW'(count_reg);
    assign idx_below_count = (idx_w < cnt_w);
    assign idx_below_depth = (idx_w < DEPTH_CMP);
    assign is_full         = (count_reg == DEPTH_C);
    assign is_empty        = (count_reg == '0);
    assign load_data       = ENTRY_WIDTH'(s_entry_data);

    // one-hot read: only the selected cell drives nonzero data
    always_comb begin
        sel_data = '0;
        for (int i = 0; i < DEPTH; i++) begin
            sel_data = sel_data | hit_q[i];
        end
    end

    // command decode: select index, cell control, next count and result
    always_comb begin
        sel              = IW'(s_index);
        ctrl             = '0;
        count_next       = count_reg;
        m_status_next    = isd_pkg::ST_OK;
        m_read_data_next = '0;
        unique case (s_command)
            isd_pkg::CMD_PUSH: begin
                sel = IW'(count_reg);
                if (is_full) begin
                    m_status_next = isd_pkg::ST_FULL;
                end else begin
                    ctrl.load  = accept;
                    count_next = count_reg + 1'b1;
                end
            end
            isd_pkg::CMD_POP: begin
                sel = IW'(count_reg - 1'b1);
                if (is_empty) begin
                    m_status_next = isd_pkg::ST_EMPTY;
                end else begin
                    count_next       = count_reg - 1'b1;
                    m_read_data_next = isd_pkg::WORD_W'(sel_data);
                end
            end
            isd_pkg::CMD_READ: begin
                if (!idx_below_count) begin
                    m_status_next = isd_pkg::ST_RANGE;
                end else begin
                    m_read_data_next = isd_pkg::WORD_W'(sel_data);
                end
            end
            isd_pkg::CMD_WRITE: begin
                if (!idx_below_depth) begin
                    m_status_next = isd_pkg::ST_RANGE;
                end else begin
                    ctrl.load = accept;
                end
            end
            isd_pkg::CMD_DELETE: begin
                if (!idx_below_count) begin
                    m_status_next = isd_pkg::ST_RANGE;
                end else begin
                    // cells above the count shift too; their contents are never read
                    ctrl.shift = accept;
                    count_next = count_reg - 1'b1;
                end
            end
            isd_pkg::CMD_CLEAR: begin
                count_next = '0;
            end
            default: begin
                // unused codes leave everything as is
            end
        endcase
    end

    // chain of cells, each fed by its upper neighbor; the top cell holds
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        if (g == DEPTH - 1) begin : g_top
            assign upper_in[g] = cell_q[g];
        end else begin : g_mid
            assign upper_in[g] = cell_q[g + 1];
        end

        isd_cell #(
            .ENTRY_WIDTH (ENTRY_WIDTH),
            .IW          (IW),
            .CELL_IDX    (g)
        ) u_cell (
            .aclk       (aclk),
            .ctrl       (ctrl),
            .sel        (sel),
            .load_data  (load_data),
            .upper_data (upper_in[g]),
            .cell_data  (cell_q[g]),
            .hit_data   (hit_q[g])
        );
    end

    // count and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg     <= 1'b0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            run_reg <= 1'b1;
            if (accept) begin
                count_reg       <= count_next;
                m_valid_reg     <= 1'b1;
                m_status_reg    <= m_status_next;
                m_read_data_reg <= m_read_data_next;
                m_count_reg     <= isd_pkg::COUNT_W'(count_next);
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_read_data   = m_read_data_reg;
    assign m_entry_count = m_count_reg;

    // checks
    `ISD_ASSERT(a_count_bound, aclk, aresetn, count_reg <= DEPTH_C,
        "entry count above capacity")
    `ISD_ASSERT_NEXT(a_push_count, aclk, aresetn,
        accept && (s_command == isd_pkg::CMD_PUSH) && !is_full,
        count_reg == $past(count_reg) + 1'b1, "push did not grow the count")
    `ISD_ASSERT_NEXT(a_idle_count, aclk, aresetn, !accept, $stable(count_reg),
        "count changed without a command")
    `ISD_ASSERT(a_err_zero, aclk, aresetn,
        !(m_valid_reg && (m_status_reg != isd_pkg::ST_OK)) || (m_read_data_reg == '0),
        "error result carries data")
    `ISD_ASSERT(a_one_load, aclk, aresetn, !(ctrl.load && ctrl.shift),
        "load and shift issued together")

endmodule

// ===== sv/isd_cell.sv =====
// one storage cell of the stack chain
`timescale 1ns / 1ps

module isd_cell #(
    parameter int unsigned ENTRY_WIDTH = 32,
    parameter int unsigned IW          = 6,
    parameter int unsigned CELL_IDX    = 0
) (
    input  logic                   aclk,
    input  isd_pkg::cell_ctrl_t    ctrl,
    input  logic [IW-1:0]          sel,
    input  logic [ENTRY_WIDTH-1:0] load_data,
    input  logic [ENTRY_WIDTH-1:0] upper_data,
    output logic [ENTRY_WIDTH-1:0] cell_data,
    output logic [ENTRY_WIDTH-1:0] hit_data
);

    localparam logic [IW-1:0] MY_IDX = IW'(CELL_IDX);

    logic [ENTRY_WIDTH-1:0] data_reg;
    logic [ENTRY_WIDTH-1:0] data_next;
    logic                   hit;

    assign hit = (sel == MY_IDX);

    always_comb begin
        data_next = data_reg;
        if (ctrl.load && hit) begin
            data_next = load_data;
        end else if (ctrl.shift && (MY_IDX >= sel)) begin
            data_next = upper_data;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign cell_data = data_reg;
    assign hit_data  = hit ? data_reg : '0;

endmodule

// ===== sim/tb_indexed_stack_with_delete_core.sv =====
// self-checking testbench for the indexed stack with delete core
`timescale 1ns / 1ps

module tb_indexed_stack_with_delete_core;

    localparam int unsigned STACK_DEPTH = 64;
    localparam int unsigned RANDOM_WORDS = 550;
    localparam int unsigned CYCLE_LIMIT = 400000;

    // codes the block decodes as no-ops
    localparam logic [isd_pkg::CMD_W-1:0] CMD_SPARE_6 = 3'd6;
    localparam logic [isd_pkg::CMD_W-1:0] CMD_SPARE_7 = 3'd7;

    // traffic mix of one random segment
    typedef enum int { MIX_GROW, MIX_DRAIN, MIX_EVEN } traffic_mix_t;

    typedef struct {
        logic [1:0]                  status;
        logic [isd_pkg::WORD_W-1:0]  data;
        logic [isd_pkg::COUNT_W-1:0] count;
    } stack_result_t;

    // shadow stack: updated on every accepted command word, queues the result it predicts
    class stack_predictor;
        logic [isd_pkg::WORD_W-1:0] entries [STACK_DEPTH];
        int unsigned                held;
        stack_result_t              pending [$];
        int unsigned                failures;

        function new();
            held = 0;
            failures = 0;
        endfunction

        function void note_command(logic [isd_pkg::CMD_W-1:0] cmd,
                                   logic [isd_pkg::INDEX_W-1:0] idx,
                                   logic [isd_pkg::WORD_W-1:0] data);
            stack_result_t r;
            r.status = isd_pkg::ST_OK;
            r.data = '0;
            case (cmd)
                isd_pkg::CMD_PUSH: begin
                    if (held >= STACK_DEPTH) begin
                        r.status = isd_pkg::ST_FULL;
                    end else begin
                        entries[held] = data;
                        held++;
                    end
                end
                isd_pkg::CMD_POP: begin
                    if (held == 0) begin
                        r.status = isd_pkg::ST_EMPTY;
                    end else begin
                        held--;
                        r.data = entries[held];
                    end
                end
                isd_pkg::CMD_READ: begin
                    if (idx >= held) r.status = isd_pkg::ST_RANGE;
                    else r.data = entries[idx];
                end
                isd_pkg::CMD_WRITE: begin
                    if (idx >= STACK_DEPTH) r.status = isd_pkg::ST_RANGE;
                    else entries[idx] = data;
                end
                isd_pkg::CMD_DELETE: begin
                    if (idx >= held) begin
                        r.status = isd_pkg::ST_RANGE;
                    end else begin
                        for (int i = idx; i + 1 < held; i++) entries[i] = entries[i + 1];
                        held--;
                    end
                end
                isd_pkg::CMD_CLEAR: held = 0;
                default: ;
            endcase
            r.count = isd_pkg::COUNT_W'(held);
            pending.push_back(r);
        endfunction

        function void check_result(logic [1:0] status, logic [isd_pkg::WORD_W-1:0] data,
                                   logic [isd_pkg::COUNT_W-1:0] count);
            stack_result_t want;
            if (pending.size() == 0) begin
                $error("result word with none expected: status %0d read_data %h count %0d",
                       status, data, count);
                failures++;
                return;
            end
            want = pending.pop_front();
            if (status !== want.status) begin
                $error("m_status expected %0d actual %0d", want.status, status);
                failures++;
            end
            if (data !== want.data) begin
                $error("m_read_data expected %h actual %h", want.data, data);
                failures++;
            end
            if (count !== want.count) begin
                $error("m_entry_count expected %0d actual %0d", want.count, count);
                failures++;
            end
        endfunction
    endclass

    logic                        aclk = 1'b0;
    logic                        aresetn = 1'b0;
    logic                        s_valid = 1'b0;
    logic                        s_ready;
    logic [isd_pkg::CMD_W-1:0]   s_command = isd_pkg::CMD_CLEAR;
    logic [isd_pkg::INDEX_W-1:0] s_index = '0;
    logic [isd_pkg::WORD_W-1:0]  s_entry_data = '0;
    logic                        m_valid;
    logic                        m_ready = 1'b0;
    logic [1:0]                  m_status;
    logic [isd_pkg::WORD_W-1:0]  m_read_data;
    logic [isd_pkg::COUNT_W-1:0] m_entry_count;

    stack_predictor book = new();
    int unsigned    cycle_count = 0;
    int unsigned    counted_words = 0;
    bit             steady = 1'b0;   // when set neither side idles
    bit             sink_on = 1'b0;

    indexed_stack_with_delete_core #(
        .DEPTH(STACK_DEPTH),
        .ENTRY_WIDTH(isd_pkg::WORD_W)
    ) uut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_command(s_command),
        .s_index(s_index),
        .s_entry_data(s_entry_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_status(m_status),
        .m_read_data(m_read_data),
        .m_entry_count(m_entry_count)
    );

    // 4 ns clock
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // watchdog on total run length
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_indexed_stack_with_delete_core NOT OK");
            $finish;
        end
    end

    // mostly short gaps, now and then a long one
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // offer one command word after an optional gap, return once it is taken
    task automatic send_command(logic [isd_pkg::CMD_W-1:0] cmd,
                                logic [isd_pkg::INDEX_W-1:0] idx,
                                logic [isd_pkg::WORD_W-1:0] data);
        int unsigned gap;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid <= 1'b1;
        s_command <= cmd;
        s_index <= idx;
        s_entry_data <= data;
        // valid stays up with a frozen word until the handshake
        do @(posedge aclk); while (!s_ready);
        book.note_command(cmd, idx, data);
        if (cmd != CMD_SPARE_6 && cmd != CMD_SPARE_7) counted_words++;
    endtask

    // index mostly inside the held range, sometimes anywhere in the field
    function automatic logic [isd_pkg::INDEX_W-1:0] pick_index();
        if (book.held > 0 && $urandom_range(0, 99) < 80)
            return isd_pkg::INDEX_W'($urandom_range(0, book.held - 1));
        return isd_pkg::INDEX_W'($urandom_range(0, (1 << isd_pkg::INDEX_W) - 1));
    endfunction

    // entry data with the all-zero and all-one corners mixed in
    function automatic logic [isd_pkg::WORD_W-1:0] pick_data();
        int unsigned r;
        r = $urandom_range(0, 19);
        if (r == 0) return '0;
        if (r == 1) return '1;
        return $urandom();
    endfunction

    // one random command word drawn from the segment's mix
    task automatic send_random(traffic_mix_t mix);
        int unsigned w;
        logic [isd_pkg::CMD_W-1:0] cmd;
        w = $urandom_range(0, 99);
        case (mix)
            MIX_GROW:  cmd = (w < 65) ? isd_pkg::CMD_PUSH :
                             (w < 72) ? isd_pkg::CMD_POP :
                             (w < 84) ? isd_pkg::CMD_READ :
                             (w < 90) ? isd_pkg::CMD_WRITE :
                             (w < 96) ? isd_pkg::CMD_DELETE : CMD_SPARE_6;
            MIX_DRAIN: cmd = (w < 15) ? isd_pkg::CMD_PUSH :
                             (w < 48) ? isd_pkg::CMD_POP :
                             (w < 74) ? isd_pkg::CMD_DELETE :
                             (w < 88) ? isd_pkg::CMD_READ :
                             (w < 96) ? isd_pkg::CMD_WRITE : CMD_SPARE_6;
            default:   cmd = (w < 30) ? isd_pkg::CMD_PUSH :
                             (w < 50) ? isd_pkg::CMD_POP :
                             (w < 70) ? isd_pkg::CMD_READ :
                             (w < 82) ? isd_pkg::CMD_WRITE :
                             (w < 96) ? isd_pkg::CMD_DELETE : CMD_SPARE_6;
        endcase
        // the tail of every mix: rare clears and the two spare codes
        if (cmd == CMD_SPARE_6) begin
            w = $urandom_range(0, 3);
            cmd = (w < 2) ? isd_pkg::CMD_CLEAR : (w == 2) ? CMD_SPARE_6 : CMD_SPARE_7;
        end
        send_command(cmd, pick_index(), pick_data());
    endtask

    // result side: runs of ready broken by random stalls
    initial begin : result_sink
        int unsigned stall_left;
        int unsigned run_left;
        stall_left = 0;
        run_left = 0;
        wait (sink_on);
        forever begin
            @(negedge aclk);
            if (stall_left == 0 && run_left == 0) begin
                stall_left = pick_gap();
                run_left = $urandom_range(1, 12);
            end
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
                run_left--;
            end
        end
    end

    // every result word taken is checked against the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            book.check_result(m_status, m_read_data, m_entry_count);
    end

    initial begin : stimulus
        traffic_mix_t mix;
        int unsigned  seg_len;
        // reset held low from the start, released on a falling edge
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        sink_on = 1'b1;

        // directed: error paths on an empty stack
        send_command(isd_pkg::CMD_POP, '0, '0);
        send_command(isd_pkg::CMD_READ, '0, '0);
        send_command(isd_pkg::CMD_DELETE, '0, '0);
        // data corners and indexed reads at and past the top
        send_command(isd_pkg::CMD_PUSH, '0, '0);
        send_command(isd_pkg::CMD_PUSH, '0, '1);
        send_command(isd_pkg::CMD_PUSH, '1, 32'ha5a5_a5a5);
        send_command(isd_pkg::CMD_READ, 6'd0, '0);
        send_command(isd_pkg::CMD_READ, 6'd2, '0);
        send_command(isd_pkg::CMD_READ, 6'd3, '0);
        send_command(isd_pkg::CMD_READ, '1, '0);
        // write above the count leaves the count alone
        send_command(isd_pkg::CMD_WRITE, '1, 32'h5a5a_5a5a);
        send_command(isd_pkg::CMD_WRITE, 6'd1, 32'h1234_5678);
        send_command(isd_pkg::CMD_READ, 6'd1, '0);
        // delete of the top word, then a delete at the bottom that shifts
        send_command(isd_pkg::CMD_DELETE, 6'd2, '0);
        send_command(isd_pkg::CMD_PUSH, '0, 32'h0000_0001);
        send_command(isd_pkg::CMD_DELETE, 6'd0, '0);
        send_command(isd_pkg::CMD_READ, 6'd0, '0);
        send_command(isd_pkg::CMD_READ, 6'd1, '0);
        send_command(isd_pkg::CMD_DELETE, '1, '0);
        // spare codes do nothing
        send_command(CMD_SPARE_6, 6'h2a, 32'hdead_beef);
        send_command(CMD_SPARE_7, 6'h15, 32'h0bad_f00d);
        send_command(isd_pkg::CMD_POP, '0, '0);
        send_command(isd_pkg::CMD_CLEAR, '0, '0);
        // a push lands on a slot written earlier above the count
        send_command(isd_pkg::CMD_WRITE, 6'd0, 32'hcafe_0000);
        send_command(isd_pkg::CMD_PUSH, '0, 32'h0000_beef);
        send_command(isd_pkg::CMD_READ, 6'd0, '0);

        // random: fill to capacity, push into a full stack, probe the top slot
        counted_words = 0;
        while (book.held < STACK_DEPTH)
            send_command(isd_pkg::CMD_PUSH, pick_index(), pick_data());
        repeat (3) send_command(isd_pkg::CMD_PUSH, pick_index(), pick_data());
        send_command(isd_pkg::CMD_READ, isd_pkg::INDEX_W'(STACK_DEPTH - 1), pick_data());
        send_command(isd_pkg::CMD_DELETE, isd_pkg::INDEX_W'(STACK_DEPTH - 1), pick_data());

        // random segments of biased traffic, some without any idling
        while (counted_words < RANDOM_WORDS) begin
            mix = traffic_mix_t'($urandom_range(0, 2));
            seg_len = $urandom_range(20, 80);
            steady = ($urandom_range(0, 4) == 0);
            repeat (seg_len) send_random(mix);
        end
        steady = 1'b0;

        @(negedge aclk);
        s_valid <= 1'b0;
        // drain outstanding predictions, then let the bench idle
        while (book.pending.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (book.failures == 0) begin
            $display("tb_indexed_stack_with_delete_core OK");
        end else begin
            $display("tb_indexed_stack_with_delete_core NOT OK");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/isd_pkg.sv
sv/isd_cell.sv
sv/indexed_stack_with_delete_core.sv
sim/tb_indexed_stack_with_delete_core.sv
